// File: rtl/core/sipmac_pkg.sv
// Shared types, constants and round function for the SipHash-2-4 MAC.
package sipmac_pkg;

    localparam int WORD_W = 64;
    localparam int CNT_W  = 4;
    localparam int LEN_W  = 8;

    // Initialization constants and the finalization mask
    localparam logic [WORD_W-1:0] SIP_C0    = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SIP_C1    = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SIP_C2    = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SIP_C3    = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } sip_state_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } cfg_reg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB2,
        ST_BLOCK1,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3,
        ST_FIN4
    } ctrl_state_t;

    // What follows the second round of an absorb
    typedef enum logic [1:0] {
        AFTER_IDLE,
        AFTER_BLOCK,
        AFTER_FIN
    } after_t;

    // Datapath operations, one SipRound each except hold
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_START,
        OP_ROUND_XOR_M,
        OP_LEN_BLOCK,
        OP_FIN_FIRST,
        OP_ROUND
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   tag_load;
    } dp_cmd_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x, input int n);
        rotl64 = (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic sip_state_t sip_round(input sip_state_t s);
        sip_state_t r;
        r = s;
        r.v0 = r.v0 + r.v1; r.v1 = rotl64(r.v1, 13); r.v1 = r.v1 ^ r.v0;
        r.v0 = rotl64(r.v0, 32);
        r.v2 = r.v2 + r.v3; r.v3 = rotl64(r.v3, 16); r.v3 = r.v3 ^ r.v2;
        r.v0 = r.v0 + r.v3; r.v3 = rotl64(r.v3, 21); r.v3 = r.v3 ^ r.v0;
        r.v2 = r.v2 + r.v1; r.v1 = rotl64(r.v1, 17); r.v1 = r.v1 ^ r.v2;
        r.v2 = rotl64(r.v2, 32);
        return r;
    endfunction

    // Keep the low cnt bytes of a word
    function automatic logic [WORD_W-1:0] byte_mask(input logic [2:0] cnt);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (3'(i) < cnt) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

// File: rtl/core/siphash_2_4_mac_top.sv
// Top level: key registers, output register, controller and datapath.
// A word that is not last takes the accept round plus one more round.
// A last word with 0..7 bytes then runs the finalization rounds; with 8 or more, a
// length-block absorb comes first. One SipRound unit runs one round per cycle;
// the last round waits while an earlier tag is not taken; the tag is valid the cycle after it.
// Synchronous active-low reset clears keys, controller, message flag, tag valid.
module siphash_2_4_mac_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [0:0]                            cfg_index,
    input  logic [sipmac_pkg::WORD_W-1:0]         cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [sipmac_pkg::WORD_W-1:0]         s_message_word,
    input  logic [sipmac_pkg::CNT_W-1:0]          s_byte_count,
    input  logic                                  s_last_word,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [sipmac_pkg::WORD_W-1:0]         m_tag
);

    logic [sipmac_pkg::WORD_W-1:0] key_low_reg, key_high_reg;
    logic [sipmac_pkg::WORD_W-1:0] tag_reg, tag_comb;
    logic                          m_valid_reg, m_valid_next;
    logic                          out_busy;
    sipmac_pkg::dp_cmd_t           cmd;

    assign cfg_ready = 1'b1;
    assign out_busy  = m_valid_reg && !m_ready;
    assign m_valid   = m_valid_reg;
    assign m_tag     = tag_reg;

    // Write key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_valid) begin
            case (sipmac_pkg::cfg_reg_t'(cfg_index))
                sipmac_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                sipmac_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the tag until the item is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.tag_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tag_load) begin
            tag_reg <= tag_comb;
        end
    end

    sipmac_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .last_word  (s_last_word),
        .count_full (s_byte_count[3]),
        .out_busy   (out_busy),
        .s_ready    (s_ready),
        .cmd        (cmd)
    );

    sipmac_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .message_word (s_message_word),
        .byte_count   (s_byte_count),
        .last_word    (s_last_word),
        .key_low      (key_low_reg),
        .key_high     (key_high_reg),
        .tag          (tag_comb)
    );

    // The tag register is never overwritten while an item waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tag_load |-> !(m_valid_reg && !m_ready))
        else $error("tag overwritten while waiting");

    // A word that is not last frees the input again once its second absorb round is done
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_last_word) |=> !s_ready ##1 s_ready)
        else $error("non-last word timing wrong");

    // A last word does not free the input during its second absorb round or the round after it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_word) |=> !s_ready ##1 !s_ready)
        else $error("last word finished too early");

    // A tag only appears from a finalization round, never while idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("tag appeared without finalization");

endmodule

// File: rtl/core/sipmac_dp.sv
// Datapath: state words, message block, length byte and one shared SipRound unit.
module sipmac_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sipmac_pkg::dp_cmd_t                  cmd,
    input  logic [sipmac_pkg::WORD_W-1:0]        message_word,
    input  logic [sipmac_pkg::CNT_W-1:0]         byte_count,
    input  logic                                 last_word,
    input  logic [sipmac_pkg::WORD_W-1:0]        key_low,
    input  logic [sipmac_pkg::WORD_W-1:0]        key_high,
    output logic [sipmac_pkg::WORD_W-1:0]        tag
);

    sipmac_pkg::sip_state_t          v_reg, v_next;
    logic [sipmac_pkg::WORD_W-1:0]   m_reg, m_next;
    logic [sipmac_pkg::LEN_W-1:0]    len_reg, len_next;
    logic                            in_msg_reg, in_msg_next;

    sipmac_pkg::sip_state_t          init_state, base_state, round_in, round_out;
    logic [sipmac_pkg::LEN_W-1:0]    len_base, len_acc;
    logic [sipmac_pkg::WORD_W-1:0]   final_block, m_acc, len_block;
    logic                            full_word;

    // Build the incoming block and the state it starts from
    always_comb begin
        init_state.v0 = sipmac_pkg::SIP_C0 ^ key_low;
        init_state.v1 = sipmac_pkg::SIP_C1 ^ key_high;
        init_state.v2 = sipmac_pkg::SIP_C2 ^ key_low;
        init_state.v3 = sipmac_pkg::SIP_C3 ^ key_high;
        base_state    = in_msg_reg ? v_reg : init_state;
        len_base      = in_msg_reg ? len_reg : '0;
        full_word     = !last_word || byte_count[3];
        len_acc       = full_word ? len_base + 8'd8 : len_base + {5'b0, byte_count[2:0]};
        final_block   = {len_acc, 56'b0}
                      | (message_word & sipmac_pkg::byte_mask(byte_count[2:0]));
        m_acc         = full_word ? message_word : final_block;
        len_block     = {len_reg, 56'b0};
    end

    // Select the round input, run one SipRound, apply post-round xor
    always_comb begin
        v_next      = v_reg;
        m_next      = m_reg;
        len_next    = len_reg;
        in_msg_next = in_msg_reg;
        round_in    = v_reg;
        case (cmd.op)
            sipmac_pkg::OP_START: begin
                round_in    = base_state;
                round_in.v3 = base_state.v3 ^ m_acc;
            end
            sipmac_pkg::OP_LEN_BLOCK: begin
                round_in.v3 = v_reg.v3 ^ len_block;
            end
            sipmac_pkg::OP_FIN_FIRST: begin
                round_in.v2 = v_reg.v2 ^ sipmac_pkg::FINAL_XOR;
            end
            default: begin
                round_in = v_reg;
            end
        endcase
        round_out = sipmac_pkg::sip_round(round_in);
        case (cmd.op)
            sipmac_pkg::OP_START: begin
                v_next      = round_out;
                m_next      = m_acc;
                len_next    = len_acc;
                in_msg_next = !last_word;
            end
            sipmac_pkg::OP_ROUND_XOR_M: begin
                v_next    = round_out;
                v_next.v0 = round_out.v0 ^ m_reg;
            end
            sipmac_pkg::OP_LEN_BLOCK: begin
                v_next = round_out;
                m_next = len_block;
            end
            sipmac_pkg::OP_FIN_FIRST,
            sipmac_pkg::OP_ROUND: begin
                v_next = round_out;
            end
            default: begin
                v_next = v_reg;
            end
        endcase
        tag = round_out.v0 ^ round_out.v1 ^ round_out.v2 ^ round_out.v3;
    end

    // Track whether a message is open
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg <= 1'b0;
        end else begin
            in_msg_reg <= in_msg_next;
        end
    end

    // Hold state words, block and length
    always_ff @(posedge aclk) begin
        v_reg   <= v_next;
        m_reg   <= m_next;
        len_reg <= len_next;
    end

endmodule

// File: rtl/core/sipmac_ctrl.sv
// Controller: sequences absorb, length-block and finalization rounds.
module sipmac_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 last_word,
    input  logic                 count_full,
    input  logic                 out_busy,
    output logic                 s_ready,
    output sipmac_pkg::dp_cmd_t  cmd
);

    sipmac_pkg::ctrl_state_t state_reg, state_next;
    sipmac_pkg::after_t      after_reg, after_next;

    // Hold state and pending continuation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sipmac_pkg::ST_IDLE;
            after_reg <= sipmac_pkg::AFTER_IDLE;
        end else begin
            state_reg <= state_next;
            after_reg <= after_next;
        end
    end

    // Choose next state and datapath command
    always_comb begin
        state_next   = state_reg;
        after_next   = after_reg;
        s_ready      = 1'b0;
        cmd.op       = sipmac_pkg::OP_HOLD;
        cmd.tag_load = 1'b0;
        case (state_reg)
            sipmac_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = sipmac_pkg::OP_START;
                    state_next = sipmac_pkg::ST_ABSORB2;
                    if (!last_word) begin
                        after_next = sipmac_pkg::AFTER_IDLE;
                    end else if (count_full) begin
                        after_next = sipmac_pkg::AFTER_BLOCK;
                    end else begin
                        after_next = sipmac_pkg::AFTER_FIN;
                    end
                end
            end
            sipmac_pkg::ST_ABSORB2: begin
                cmd.op = sipmac_pkg::OP_ROUND_XOR_M;
                case (after_reg)
                    sipmac_pkg::AFTER_BLOCK: state_next = sipmac_pkg::ST_BLOCK1;
                    sipmac_pkg::AFTER_FIN:   state_next = sipmac_pkg::ST_FIN1;
                    default:                 state_next = sipmac_pkg::ST_IDLE;
                endcase
            end
            sipmac_pkg::ST_BLOCK1: begin
                cmd.op     = sipmac_pkg::OP_LEN_BLOCK;
                after_next = sipmac_pkg::AFTER_FIN;
                state_next = sipmac_pkg::ST_ABSORB2;
            end
            sipmac_pkg::ST_FIN1: begin
                cmd.op     = sipmac_pkg::OP_FIN_FIRST;
                state_next = sipmac_pkg::ST_FIN2;
            end
            sipmac_pkg::ST_FIN2: begin
                cmd.op     = sipmac_pkg::OP_ROUND;
                state_next = sipmac_pkg::ST_FIN3;
            end
            sipmac_pkg::ST_FIN3: begin
                cmd.op     = sipmac_pkg::OP_ROUND;
                state_next = sipmac_pkg::ST_FIN4;
            end
            sipmac_pkg::ST_FIN4: begin
                // Stall the last round until the output register is free
                if (!out_busy) begin
                    cmd.op       = sipmac_pkg::OP_ROUND;
                    cmd.tag_load = 1'b1;
                    state_next   = sipmac_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sipmac_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the SipHash-2-4 MAC top level.
`timescale 1ns / 1ps

module tb_top;
    import sipmac_pkg::*;

    localparam int      ITEMS_PER_PHASE = 310;
    localparam int      NUM_PHASES      = 6;
    localparam int      FLUSH_CYCLES    = 16;
    localparam int      DRAIN_LIMIT     = 20000;
    localparam longint  TIMEOUT_NS      = 10_000_000;

    // Outcome of checking one tag
    typedef enum int {
        CHK_MATCH,
        CHK_MISMATCH,
        CHK_NONE_EXPECTED
    } chk_result_t;

    // Bit-accurate tag predictor plus the queue of tags still to come
    class tag_scoreboard;
        logic [WORD_W-1:0] key_lo;
        logic [WORD_W-1:0] key_hi;
        logic [WORD_W-1:0] v0, v1, v2, v3;
        logic [LEN_W-1:0]  msg_len;
        bit                open_msg;
        logic [WORD_W-1:0] expected_tags[$];
        logic [WORD_W-1:0] want_tag;

        function new();
            key_lo   = '0;
            key_hi   = '0;
            v0       = '0;
            v1       = '0;
            v2       = '0;
            v3       = '0;
            msg_len  = '0;
            open_msg = 1'b0;
            want_tag = '0;
        endfunction

        function void set_key(cfg_reg_t idx, logic [WORD_W-1:0] data);
            if (idx == REG_KEY_LOW) begin
                key_lo = data;
            end else begin
                key_hi = data;
            end
        endfunction

        function logic [WORD_W-1:0] rol(logic [WORD_W-1:0] x, int n);
            return (x << n) | (x >> (WORD_W - n));
        endfunction

        function void mix_round();
            v0 = v0 + v1; v1 = rol(v1, 13); v1 = v1 ^ v0; v0 = rol(v0, 32);
            v2 = v2 + v3; v3 = rol(v3, 16); v3 = v3 ^ v2;
            v0 = v0 + v3; v3 = rol(v3, 21); v3 = v3 ^ v0;
            v2 = v2 + v1; v1 = rol(v1, 17); v1 = v1 ^ v2; v2 = rol(v2, 32);
        endfunction

        function void absorb_block(logic [WORD_W-1:0] m);
            v3 = v3 ^ m;
            mix_round();
            mix_round();
            v0 = v0 ^ m;
        endfunction

        // Advance the state by one accepted word; queue a tag on the last one
        function void absorb_word(logic [WORD_W-1:0] word, logic [CNT_W-1:0] cnt,
                                  logic last);
            logic [CNT_W-1:0]  n;
            logic [WORD_W-1:0] w;
            logic [WORD_W-1:0] blk;
            n = cnt;
            w = word;
            if (!open_msg) begin
                v0       = SIP_C0 ^ key_lo;
                v1       = SIP_C1 ^ key_hi;
                v2       = SIP_C2 ^ key_lo;
                v3       = SIP_C3 ^ key_hi;
                msg_len  = '0;
                open_msg = 1'b1;
            end
            // Full words, and a last word of eight or more bytes, go in whole
            if (!last || n >= 4'd8) begin
                absorb_block(w);
                msg_len = msg_len + 8'd8;
                if (!last) begin
                    return;
                end
                n = '0;
                w = '0;
            end
            msg_len = msg_len + LEN_W'(n);
            if (n == 0) begin
                w = '0;
            end else begin
                w = w & ({WORD_W{1'b1}} >> (WORD_W - 8 * n));
            end
            blk = {msg_len, 56'd0} | w;
            absorb_block(blk);
            v2 = v2 ^ FINAL_XOR;
            repeat (4) mix_round();
            expected_tags.push_back(v0 ^ v1 ^ v2 ^ v3);
            open_msg = 1'b0;
        endfunction

        // Compare a received tag with the oldest prediction
        function chk_result_t check_tag(logic [WORD_W-1:0] got);
            if (expected_tags.size() == 0) begin
                return CHK_NONE_EXPECTED;
            end
            want_tag = expected_tags.pop_front();
            return (got === want_tag) ? CHK_MATCH : CHK_MISMATCH;
        endfunction

        function int pending();
            return expected_tags.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [0:0]           cfg_index;
    logic [WORD_W-1:0]    cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [WORD_W-1:0]    s_message_word;
    logic [CNT_W-1:0]     s_byte_count;
    logic                 s_last_word;
    logic                 m_valid;
    logic                 m_ready;
    logic [WORD_W-1:0]    m_tag;

    tag_scoreboard sb;
    int            errors;
    int            items_sent;

    siphash_2_4_mac_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_word (s_message_word),
        .s_byte_count   (s_byte_count),
        .s_last_word    (s_last_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tag          (m_tag)
    );

    // Clock: 10 ns period
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Present one item, hold it until accepted, then note it
    task automatic send_word(logic [WORD_W-1:0] word, logic [CNT_W-1:0] cnt, logic last,
                             int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_message_word = word;
        s_byte_count   = cnt;
        s_last_word    = last;
        do @(posedge aclk); while (!s_ready);
        sb.absorb_word(word, cnt, last);
        items_sent++;
    endtask

    // Drop valid and wait for every queued tag, then let the block settle
    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (sb.pending() != 0) begin
            report_error($sformatf("%0d tags never arrived", sb.pending()));
        end
        repeat (FLUSH_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [WORD_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_key(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_key(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
        write_reg(REG_KEY_LOW, lo);
        write_reg(REG_KEY_HIGH, hi);
    endtask

    // One random message: mostly short, some long enough to wrap the length byte
    task automatic send_message(bit burst);
        int               nwords;
        int               r;
        logic [CNT_W-1:0] cnt;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            nwords = $urandom_range(1, 4);
        end else if (r < 95) begin
            nwords = $urandom_range(5, 12);
        end else begin
            nwords = $urandom_range(30, 40);
        end
        for (int i = 0; i < nwords - 1; i++) begin
            send_word(rand_word(), CNT_W'($urandom_range(0, 15)), 1'b0,
                      burst ? 0 : pick_gap());
        end
        if ($urandom_range(0, 99) < 85) begin
            cnt = CNT_W'($urandom_range(0, 8));
        end else begin
            cnt = CNT_W'($urandom_range(9, 15));
        end
        send_word(rand_word(), cnt, 1'b1, burst ? 0 : pick_gap());
    endtask

    // Check each accepted tag against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            case (sb.check_tag(m_tag))
                CHK_MISMATCH: report_error($sformatf("tag mismatch: got %h want %h",
                                                     m_tag, sb.want_tag));
                CHK_NONE_EXPECTED: report_error($sformatf("unexpected tag %h", m_tag));
                default: ;
            endcase
        end
    end

    // Receiver: alternate ready runs and stalls
    initial begin
        int run;
        m_ready = 1'b0;
        forever begin
            run = $urandom_range(1, 40);
            @(negedge aclk);
            m_ready = 1'b1;
            repeat (run - 1) @(negedge aclk);
            run = pick_gap();
            if (run > 0) begin
                @(negedge aclk);
                m_ready = 1'b0;
                repeat (run - 1) @(negedge aclk);
            end
        end
    end

    // Hard stop if the run hangs
    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence
    initial begin
        int phase_items;
        sb             = new();
        errors         = 0;
        items_sent     = 0;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_message_word = '0;
        s_byte_count   = '0;
        s_last_word    = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (FLUSH_CYCLES) @(posedge aclk);

        // Directed: byte key 00..0f
        load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
        // Empty message with garbage in the word
        send_word({WORD_W{1'b1}}, 4'd0, 1'b1, 0);
        // Single-word messages of 1..8 bytes, unused bytes all ones or random
        for (int c = 1; c <= 8; c++) begin
            send_word((c % 2) ? {WORD_W{1'b1}} : rand_word(), CNT_W'(c), 1'b1, c % 3);
        end
        // Byte counts above eight saturate
        send_word({WORD_W{1'b0}}, 4'd15, 1'b1, 0);
        send_word(rand_word(), 4'd9, 1'b1, 0);
        // Counts on words that are not last are ignored
        send_word({WORD_W{1'b1}}, 4'd0, 1'b0, 0);
        send_word({WORD_W{1'b0}}, 4'd15, 1'b0, 0);
        send_word(rand_word(), 4'd3, 1'b1, 0);
        // Key change between words of one message takes effect on the next one
        send_word(rand_word(), 4'd5, 1'b0, 1);
        wait_drained();
        load_key(rand_word(), rand_word());
        send_word(rand_word(), 4'd8, 1'b1, 0);
        send_word(rand_word(), 4'd7, 1'b1, 0);
        wait_drained();

        // Random phases, each under a new key
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: load_key({WORD_W{1'b0}}, {WORD_W{1'b0}});
                1: load_key({WORD_W{1'b1}}, {WORD_W{1'b1}});
                2: load_key({WORD_W{1'b0}}, {WORD_W{1'b1}});
                default: load_key(rand_word(), rand_word());
            endcase
            phase_items = items_sent;
            while (items_sent - phase_items < ITEMS_PER_PHASE) begin
                // Now and then hold off until all tags are back
                if ($urandom_range(0, 49) == 0) begin
                    wait_drained();
                end
                send_message($urandom_range(0, 3) == 0);
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sipmac_pkg.sv
rtl/core/sipmac_dp.sv
rtl/core/sipmac_ctrl.sv
rtl/core/siphash_2_4_mac_top.sv
dv/tb_top.sv
